/* src/assert_macros.svh */
// assertion macros shared by the rtl
// each one samples on clk and is off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge
`define AMO_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// condition that must hold on the same edge as a trigger
`define AMO_CHECK_SAME(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// condition that must hold at the clock edge after a trigger
`define AMO_CHECK_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

/* src/amo_pkg.sv */
`timescale 1ns / 1ps

package amo_pkg;

	typedef enum logic [3:0] {
		OP_LR   = 4'd0,
		OP_SC   = 4'd1,
		OP_SWAP = 4'd2,
		OP_ADD  = 4'd3,
		OP_XOR  = 4'd4,
		OP_AND  = 4'd5,
		OP_OR   = 4'd6,
		OP_MIN  = 4'd7,
		OP_MAX  = 4'd8,
		OP_MINU = 4'd9,
		OP_MAXU = 4'd10
	} opcode_t;

	typedef enum logic [1:0] {
		TRAP_NONE       = 2'd0,
		TRAP_LOAD_ALIGN = 2'd1,
		TRAP_AMO_ALIGN  = 2'd2,
		TRAP_LOAD_FAULT = 2'd3
	} trap_t;

	localparam int unsigned XLEN = 64;
	localparam int unsigned WLEN = 32;

	localparam logic [XLEN-1:0] SIGN_BIT = {1'b1, {(XLEN-1){1'b0}}};

endpackage

/* src/amo_if.sv */
`timescale 1ns / 1ps

interface amo_req_if;
	logic                      valid;
	logic                      ready;
	logic [3:0]                opcode;
	logic                      is_double;
	logic [amo_pkg::XLEN-1:0]  address;
	logic [amo_pkg::XLEN-1:0]  operand;
	logic [amo_pkg::XLEN-1:0]  mem_data;
	logic                      mem_fault;

	modport source (
		output valid, opcode, is_double, address, operand, mem_data, mem_fault,
		input  ready
	);
	modport sink (
		input  valid, opcode, is_double, address, operand, mem_data, mem_fault,
		output ready
	);
endinterface

interface amo_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [amo_pkg::XLEN-1:0]  rd_value;
	logic                      rd_write;
	logic                      store_enable;
	logic [amo_pkg::XLEN-1:0]  store_data;
	logic [1:0]                trap_code;

	modport source (
		output valid, rd_value, rd_write, store_enable, store_data, trap_code,
		input  ready
	);
	modport sink (
		input  valid, rd_value, rd_write, store_enable, store_data, trap_code,
		output ready
	);
endinterface

/* src/atomic_memory_op_unit_core.sv */
`timescale 1ns / 1ps
// channel  dir  word
// req      in   opcode, is_double, address, operand, mem_data, mem_fault
// rsp      out  rd_value, rd_write, store_enable, store_data, trap_code
//
// one word per cycle sustained while rsp does not stall
// input register, then alu, alignment check and reservation compare into the result register
// the reservation updates as a word moves into the result register, so words see it in order
// reset clears the valid bits and the reservation
// a stalled rsp holds its word while req still fills the input register

`include "assert_macros.svh"

module atomic_memory_op_unit_core (
	input  logic            clk,
	input  logic            arst_n,
	amo_req_if.sink         req,
	amo_rsp_if.source       rsp
);

	localparam int unsigned XLEN = amo_pkg::XLEN;
	localparam int unsigned WLEN = amo_pkg::WLEN;

	logic                valid_s1;
	logic [3:0]          opcode_s1;
	logic                is_double_s1;
	logic [XLEN-1:0]     address_s1;
	logic [XLEN-1:0]     operand_s1;
	logic [XLEN-1:0]     mem_data_s1;
	logic                mem_fault_s1;

	logic                valid_s2;
	logic [XLEN-1:0]     rd_value_s2;
	logic                rd_write_s2;
	logic                store_enable_s2;
	logic [XLEN-1:0]     store_data_s2;
	amo_pkg::trap_t      trap_s2;

	logic                resv_valid_q;
	logic [XLEN-1:0]     resv_address_q;
	logic                resv_is_double_q;

	logic                out_free;
	logic                advance;
	logic                misaligned;
	logic                resv_hit;

	logic [XLEN-1:0]     rd_value_d;
	logic                rd_write_d;
	logic                store_enable_d;
	logic [XLEN-1:0]     store_data_d;
	amo_pkg::trap_t      trap_d;
	logic                resv_set;
	logic                resv_clear;

	assign out_free  = !valid_s2 || rsp.ready;
	assign advance   = valid_s1 && out_free;
	assign req.ready = !valid_s1 || out_free;

	assign misaligned = is_double_s1 ? (|address_s1[2:0]) : (|address_s1[1:0]);
	assign resv_hit   = resv_valid_q && (resv_is_double_q == is_double_s1)
		&& (resv_address_q == address_s1);

	always_comb begin
		logic [XLEN-1:0] mem_sx;
		logic [XLEN-1:0] opnd_sx;
		logic [XLEN-1:0] a;
		logic [XLEN-1:0] b;
		logic            unsigned_op;
		logic            lt;
		logic [XLEN-1:0] alu;

		mem_sx  = {{(XLEN-WLEN){mem_data_s1[WLEN-1]}}, mem_data_s1[WLEN-1:0]};
		opnd_sx = {{(XLEN-WLEN){operand_s1[WLEN-1]}}, operand_s1[WLEN-1:0]};
		unsigned_op = (opcode_s1 == amo_pkg::OP_MINU) || (opcode_s1 == amo_pkg::OP_MAXU);

		if (is_double_s1) begin
			a = mem_data_s1;
			b = operand_s1;
		end else if (unsigned_op) begin
			a = {{(XLEN-WLEN){1'b0}}, mem_data_s1[WLEN-1:0]};
			b = {{(XLEN-WLEN){1'b0}}, operand_s1[WLEN-1:0]};
		end else begin
			a = mem_sx;
			b = opnd_sx;
		end

		if (unsigned_op) begin
			lt = a < b;
		end else begin
			lt = (a ^ amo_pkg::SIGN_BIT) < (b ^ amo_pkg::SIGN_BIT);
		end

		case (opcode_s1)
			amo_pkg::OP_SWAP: alu = b;
			amo_pkg::OP_ADD:  alu = a + b;
			amo_pkg::OP_XOR:  alu = a ^ b;
			amo_pkg::OP_AND:  alu = a & b;
			amo_pkg::OP_OR:   alu = a | b;
			amo_pkg::OP_MIN,
			amo_pkg::OP_MINU: alu = lt ? a : b;
			default:          alu = lt ? b : a;
		endcase

		rd_value_d     = '0;
		rd_write_d     = 1'b0;
		store_enable_d = 1'b0;
		store_data_d   = '0;
		trap_d         = amo_pkg::TRAP_NONE;
		resv_set       = 1'b0;
		resv_clear     = 1'b0;

		if (opcode_s1 == amo_pkg::OP_LR) begin
			if (misaligned) begin
				trap_d = amo_pkg::TRAP_LOAD_ALIGN;
			end else if (mem_fault_s1) begin
				trap_d = amo_pkg::TRAP_LOAD_FAULT;
			end else begin
				rd_value_d = is_double_s1 ? mem_data_s1 : mem_sx;
				rd_write_d = 1'b1;
				resv_set   = 1'b1;
			end
		end else if (opcode_s1 == amo_pkg::OP_SC) begin
			if (misaligned) begin
				trap_d = amo_pkg::TRAP_AMO_ALIGN;
			end else begin
				if (resv_hit) begin
					store_enable_d = 1'b1;
					store_data_d   = is_double_s1 ? operand_s1
						: {{(XLEN-WLEN){1'b0}}, operand_s1[WLEN-1:0]};
				end else begin
					rd_value_d = {{(XLEN-1){1'b0}}, 1'b1};
				end
				rd_write_d = 1'b1;
				resv_clear = 1'b1;
			end
		end else if (opcode_s1 inside {[amo_pkg::OP_SWAP:amo_pkg::OP_MAXU]}) begin
			if (misaligned) begin
				trap_d = amo_pkg::TRAP_AMO_ALIGN;
			end else if (mem_fault_s1) begin
				trap_d = amo_pkg::TRAP_LOAD_FAULT;
			end else begin
				rd_value_d     = is_double_s1 ? mem_data_s1 : mem_sx;
				rd_write_d     = 1'b1;
				store_enable_d = 1'b1;
				store_data_d   = is_double_s1 ? alu
					: {{(XLEN-WLEN){1'b0}}, alu[WLEN-1:0]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			opcode_s1    <= req.opcode;
			is_double_s1 <= req.is_double;
			address_s1   <= req.address;
			operand_s1   <= req.operand;
			mem_data_s1  <= req.mem_data;
			mem_fault_s1 <= req.mem_fault;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rd_value_s2     <= rd_value_d;
			rd_write_s2     <= rd_write_d;
			store_enable_s2 <= store_enable_d;
			store_data_s2   <= store_data_d;
			trap_s2         <= trap_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resv_valid_q     <= 1'b0;
			resv_address_q   <= '0;
			resv_is_double_q <= 1'b0;
		end else if (advance) begin
			if (resv_set) begin
				resv_valid_q     <= 1'b1;
				resv_address_q   <= address_s1;
				resv_is_double_q <= is_double_s1;
			end else if (resv_clear) begin
				resv_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid        = valid_s2;
	assign rsp.rd_value     = rd_value_s2;
	assign rsp.rd_write     = rd_write_s2;
	assign rsp.store_enable = store_enable_s2;
	assign rsp.store_data   = store_data_s2;
	assign rsp.trap_code    = trap_s2;

	`AMO_CHECK(a_ready_only_when_full, req.ready || valid_s1, "input stall with empty stage")
	`AMO_CHECK_SAME(a_trap_quiet, rsp.valid && (rsp.trap_code != amo_pkg::TRAP_NONE),
		!rsp.rd_write && !rsp.store_enable && (rsp.rd_value == '0) && (rsp.store_data == '0),
		"trap word carries side effects")
	`AMO_CHECK_SAME(a_store_no_trap, rsp.valid && rsp.store_enable,
		rsp.rd_write && (rsp.trap_code == amo_pkg::TRAP_NONE), "store on a trapping word")
	`AMO_CHECK_NEXT(a_sc_clears_resv, advance && (opcode_s1 == amo_pkg::OP_SC) && !misaligned,
		!resv_valid_q, "reservation survives sc")
	`AMO_CHECK_NEXT(a_lr_sets_resv, advance && resv_set,
		resv_valid_q && (resv_address_q == $past(address_s1)), "lr left no reservation")

endmodule

/* tb/tb_atomic_memory_op_unit_core.sv */
`timescale 1ns / 1ps

module tb_atomic_memory_op_unit_core;

	localparam int unsigned XLEN = amo_pkg::XLEN;
	localparam int unsigned WLEN = amo_pkg::WLEN;

	localparam int unsigned RANDOM_ITEMS = 600;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned SETTLE_CYCLES = 8;

	// opcodes with no operation behind them
	localparam logic [3:0] OP_UNUSED_LO = 4'd11;
	localparam logic [3:0] OP_UNUSED_HI = 4'd15;

	typedef struct packed {
		logic [3:0]      opcode;
		logic            is_double;
		logic [XLEN-1:0] address;
		logic [XLEN-1:0] operand;
		logic [XLEN-1:0] mem_data;
		logic            mem_fault;
	} amo_req_t;

	typedef struct packed {
		logic [XLEN-1:0] rd_value;
		logic            rd_write;
		logic            store_enable;
		logic [XLEN-1:0] store_data;
		logic [1:0]      trap_code;
	} amo_rsp_t;

	class amo_scoreboard;
		logic            resv_valid;
		logic [XLEN-1:0] resv_address;
		logic            resv_is_double;
		amo_rsp_t        expected_rsps[$];
		int unsigned     errors;

		function new();
			resv_valid = 1'b0;
			resv_address = '0;
			resv_is_double = 1'b0;
			errors = 0;
		endfunction

		function logic [XLEN-1:0] sext_word(logic [XLEN-1:0] v);
			return {{(XLEN-WLEN){v[WLEN-1]}}, v[WLEN-1:0]};
		endfunction

		function logic [XLEN-1:0] amo_alu(logic [3:0] op, logic [XLEN-1:0] a,
				logic [XLEN-1:0] b);
			case (op)
				amo_pkg::OP_SWAP: return b;
				amo_pkg::OP_ADD:  return a + b;
				amo_pkg::OP_XOR:  return a ^ b;
				amo_pkg::OP_AND:  return a & b;
				amo_pkg::OP_OR:   return a | b;
				amo_pkg::OP_MIN:  return ($signed(a) < $signed(b)) ? a : b;
				amo_pkg::OP_MAX:  return ($signed(a) < $signed(b)) ? b : a;
				amo_pkg::OP_MINU: return (a < b) ? a : b;
				default:          return (a < b) ? b : a;
			endcase
		endfunction

		function amo_rsp_t predict_amo(amo_req_t r);
			amo_rsp_t        res;
			logic            misaligned;
			logic            unsigned_cmp;
			logic [XLEN-1:0] a;
			logic [XLEN-1:0] b;
			logic [XLEN-1:0] sum;
			res = '0;
			misaligned = r.is_double ? (r.address[2:0] != 3'd0) : (r.address[1:0] != 2'd0);
			case (r.opcode)
				amo_pkg::OP_LR: begin
					if (misaligned) begin
						res.trap_code = amo_pkg::TRAP_LOAD_ALIGN;
					end else if (r.mem_fault) begin
						res.trap_code = amo_pkg::TRAP_LOAD_FAULT;
					end else begin
						res.rd_value = r.is_double ? r.mem_data : sext_word(r.mem_data);
						res.rd_write = 1'b1;
						resv_valid = 1'b1;
						resv_address = r.address;
						resv_is_double = r.is_double;
					end
				end
				amo_pkg::OP_SC: begin
					if (misaligned) begin
						res.trap_code = amo_pkg::TRAP_AMO_ALIGN;
					end else begin
						if (resv_valid && resv_is_double == r.is_double
								&& resv_address == r.address) begin
							res.store_enable = 1'b1;
							res.store_data = r.is_double ? r.operand
								: {{(XLEN-WLEN){1'b0}}, r.operand[WLEN-1:0]};
						end else begin
							res.rd_value = {{(XLEN-1){1'b0}}, 1'b1};
						end
						res.rd_write = 1'b1;
						resv_valid = 1'b0;
					end
				end
				amo_pkg::OP_SWAP, amo_pkg::OP_ADD, amo_pkg::OP_XOR, amo_pkg::OP_AND,
						amo_pkg::OP_OR, amo_pkg::OP_MIN, amo_pkg::OP_MAX,
						amo_pkg::OP_MINU, amo_pkg::OP_MAXU: begin
					if (misaligned) begin
						res.trap_code = amo_pkg::TRAP_AMO_ALIGN;
					end else if (r.mem_fault) begin
						res.trap_code = amo_pkg::TRAP_LOAD_FAULT;
					end else if (r.is_double) begin
						res.rd_value = r.mem_data;
						res.rd_write = 1'b1;
						res.store_enable = 1'b1;
						res.store_data = amo_alu(r.opcode, r.mem_data, r.operand);
					end else begin
						unsigned_cmp = (r.opcode == amo_pkg::OP_MINU)
							|| (r.opcode == amo_pkg::OP_MAXU);
						a = unsigned_cmp ? {{(XLEN-WLEN){1'b0}}, r.mem_data[WLEN-1:0]}
							: sext_word(r.mem_data);
						b = unsigned_cmp ? {{(XLEN-WLEN){1'b0}}, r.operand[WLEN-1:0]}
							: sext_word(r.operand);
						sum = amo_alu(r.opcode, a, b);
						res.rd_value = sext_word(r.mem_data);
						res.rd_write = 1'b1;
						res.store_enable = 1'b1;
						res.store_data = {{(XLEN-WLEN){1'b0}}, sum[WLEN-1:0]};
					end
				end
				default: ;
			endcase
			return res;
		endfunction

		function void note_request(amo_req_t r);
			expected_rsps.push_back(predict_amo(r));
		endfunction

		function void check_result(amo_rsp_t got);
			amo_rsp_t want;
			if (expected_rsps.size() == 0) begin
				$error("unexpected result word: rd_value %h trap_code %0d",
					got.rd_value, got.trap_code);
				errors++;
				return;
			end
			want = expected_rsps.pop_front();
			if (got.rd_value !== want.rd_value) begin
				$error("rd_value: expected %h, actual %h", want.rd_value, got.rd_value);
				errors++;
			end
			if (got.rd_write !== want.rd_write) begin
				$error("rd_write: expected %b, actual %b", want.rd_write, got.rd_write);
				errors++;
			end
			if (got.store_enable !== want.store_enable) begin
				$error("store_enable: expected %b, actual %b",
					want.store_enable, got.store_enable);
				errors++;
			end
			if (got.store_data !== want.store_data) begin
				$error("store_data: expected %h, actual %h", want.store_data, got.store_data);
				errors++;
			end
			if (got.trap_code !== want.trap_code) begin
				$error("trap_code: expected %0d, actual %0d", want.trap_code, got.trap_code);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	amo_req_if req_ch();
	amo_rsp_if rsp_ch();

	atomic_memory_op_unit_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	amo_scoreboard   amo_sb = new();
	bit              calm = 1'b0;
	int unsigned     gap_pct = 20;
	int unsigned     sent_count = 0;
	logic [XLEN-1:0] addr_pool[4];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		int unsigned cycles;
		for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
		$display("TEST FAILED");
		$finish;
	end

	// result side stalls
	initial begin
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			rsp_ch.ready <= 1'b1;
			if (calm) begin
				@(posedge clk);
			end else begin
				if ($urandom_range(0, 7) == 0)
					repeat ($urandom_range(50, 150)) @(posedge clk);
				else
					repeat ($urandom_range(1, 20)) @(posedge clk);
				if (!calm) begin
					rsp_ch.ready <= 1'b0;
					repeat ($urandom_range(1, 17)) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		amo_rsp_t got;
		amo_req_t seen;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.rd_value = rsp_ch.rd_value;
				got.rd_write = rsp_ch.rd_write;
				got.store_enable = rsp_ch.store_enable;
				got.store_data = rsp_ch.store_data;
				got.trap_code = rsp_ch.trap_code;
				amo_sb.check_result(got);
			end
			if (req_ch.valid && req_ch.ready) begin
				seen.opcode = req_ch.opcode;
				seen.is_double = req_ch.is_double;
				seen.address = req_ch.address;
				seen.operand = req_ch.operand;
				seen.mem_data = req_ch.mem_data;
				seen.mem_fault = req_ch.mem_fault;
				amo_sb.note_request(seen);
			end
		end
	end

	function automatic amo_req_t make_req(logic [3:0] op, logic dbl, logic [XLEN-1:0] addr,
			logic [XLEN-1:0] opnd, logic [XLEN-1:0] mem, logic fault);
		amo_req_t r;
		r.opcode = op;
		r.is_double = dbl;
		r.address = addr;
		r.operand = opnd;
		r.mem_data = mem;
		r.mem_fault = fault;
		return r;
	endfunction

	function automatic logic [XLEN-1:0] rand_value();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(0, 11))
			0: return '0;
			1: return '1;
			2: return amo_pkg::SIGN_BIT;
			3: return ~amo_pkg::SIGN_BIT;
			4: return 64'h0000_0000_8000_0000;
			5: return 64'h0000_0000_7FFF_FFFF;
			6: return {{32{w[31]}}, w};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic rare();
		return $urandom_range(0, 15) == 0;
	endfunction

	function automatic logic [XLEN-1:0] pick_address(logic dbl, logic aligned);
		logic [XLEN-1:0] a;
		a = addr_pool[$urandom_range(0, 3)];
		if (!dbl)
			a[2] = 1'($urandom_range(0, 1));
		if (!aligned)
			a[2:0] = dbl ? 3'($urandom_range(1, 7)) : {a[2], 2'($urandom_range(1, 3))};
		return a;
	endfunction

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (amo_sb.expected_rsps.size() != 0);
	endtask

	task automatic send_request(input amo_req_t r);
		int unsigned pick;
		req_ch.valid <= 1'b1;
		req_ch.opcode <= r.opcode;
		req_ch.is_double <= r.is_double;
		req_ch.address <= r.address;
		req_ch.operand <= r.operand;
		req_ch.mem_data <= r.mem_data;
		req_ch.mem_fault <= r.mem_fault;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sent_count++;
		pick = $urandom_range(0, 99);
		if (!calm && pick < gap_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end else if (!calm && pick == 99) begin
			drain_results();
		end
	endtask

	task automatic random_amo();
		logic [3:0] op;
		logic       dbl;
		op = 4'($urandom_range(amo_pkg::OP_SWAP, amo_pkg::OP_MAXU));
		dbl = 1'($urandom_range(0, 1));
		send_request(make_req(op, dbl, pick_address(dbl, !rare()), rand_value(), rand_value(),
			rare()));
	endtask

	task automatic random_noise();
		send_request(make_req(4'($urandom_range(0, 15)), 1'($urandom), {$urandom, $urandom},
			rand_value(), rand_value(), 1'($urandom)));
	endtask

	// reserve, maybe disturb, then conditional store
	task automatic lr_sc_sequence();
		logic            dbl;
		logic            sc_dbl;
		logic [XLEN-1:0] addr;
		logic [XLEN-1:0] sc_addr;
		int unsigned     variant;
		dbl = 1'($urandom_range(0, 1));
		addr = pick_address(dbl, !rare());
		send_request(make_req(amo_pkg::OP_LR, dbl, addr, rand_value(), rand_value(), rare()));
		repeat ($urandom_range(0, 2)) random_amo();
		sc_addr = addr;
		sc_dbl = dbl;
		variant = $urandom_range(0, 9);
		if (variant == 7)
			sc_dbl = !dbl;
		else if (variant == 8)
			sc_addr = pick_address(dbl, 1'b1);
		send_request(make_req(amo_pkg::OP_SC, sc_dbl, sc_addr, rand_value(), rand_value(),
			1'($urandom)));
		if (variant == 9)
			send_request(make_req(amo_pkg::OP_SC, sc_dbl, sc_addr, rand_value(), rand_value(),
				1'b0));
	endtask

	initial begin
		int unsigned base;
		int unsigned kind;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.opcode <= '0;
		req_ch.is_double <= 1'b0;
		req_ch.address <= '0;
		req_ch.operand <= '0;
		req_ch.mem_data <= '0;
		req_ch.mem_fault <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		send_request(make_req(amo_pkg::OP_LR, 1'b0, 64'h1000, '0, 64'hFFFF_FFFF_8000_0000,
			1'b0));
		send_request(make_req(amo_pkg::OP_SC, 1'b0, 64'h1000, '1, '0, 1'b0));
		send_request(make_req(amo_pkg::OP_SC, 1'b0, 64'h1000, '1, '0, 1'b0));
		send_request(make_req(amo_pkg::OP_LR, 1'b1, 64'hFFFF_FFFF_FFFF_FFF8, '0, '1, 1'b0));
		send_request(make_req(amo_pkg::OP_SC, 1'b0, 64'hFFFF_FFFF_FFFF_FFF8, '1, '1, 1'b0));
		send_request(make_req(amo_pkg::OP_LR, 1'b1, 64'h2000, '1, '0, 1'b0));
		send_request(make_req(amo_pkg::OP_SC, 1'b1, 64'h2008, '1, '0, 1'b0));
		send_request(make_req(amo_pkg::OP_LR, 1'b0, 64'h2004, '0, 64'h7FFF_FFFF, 1'b0));
		send_request(make_req(amo_pkg::OP_SC, 1'b0, 64'h2004, amo_pkg::SIGN_BIT, '1, 1'b1));
		send_request(make_req(amo_pkg::OP_LR, 1'b0, 64'h3, '0, '1, 1'b0));
		send_request(make_req(amo_pkg::OP_LR, 1'b1, 64'h4, '0, '1, 1'b0));
		send_request(make_req(amo_pkg::OP_LR, 1'b0, 64'h10, '0, '1, 1'b1));
		send_request(make_req(amo_pkg::OP_SC, 1'b1, 64'hC, '1, '0, 1'b0));
		send_request(make_req(amo_pkg::OP_SWAP, 1'b1, 64'h18, amo_pkg::SIGN_BIT,
			~amo_pkg::SIGN_BIT, 1'b0));
		send_request(make_req(amo_pkg::OP_ADD, 1'b0, 64'h20, 64'h1, 64'h7FFF_FFFF, 1'b0));
		send_request(make_req(amo_pkg::OP_ADD, 1'b1, 64'h28, 64'h1, '1, 1'b0));
		send_request(make_req(amo_pkg::OP_XOR, 1'b0, 64'h24, 64'hFFFF_FFFF, 64'h0F0F_0F0F,
			1'b0));
		send_request(make_req(amo_pkg::OP_AND, 1'b1, 64'h30, 64'hF0F0_F0F0_F0F0_F0F0, '1,
			1'b0));
		send_request(make_req(amo_pkg::OP_OR, 1'b0, 64'h34, 64'h8000_0000, 64'h1, 1'b0));
		send_request(make_req(amo_pkg::OP_MIN, 1'b0, 64'h38, 64'h7FFF_FFFF, 64'h8000_0000,
			1'b0));
		send_request(make_req(amo_pkg::OP_MAX, 1'b1, 64'h40, ~amo_pkg::SIGN_BIT,
			amo_pkg::SIGN_BIT, 1'b0));
		send_request(make_req(amo_pkg::OP_MINU, 1'b0, 64'h44, 64'h7FFF_FFFF, 64'h8000_0000,
			1'b0));
		send_request(make_req(amo_pkg::OP_MAXU, 1'b1, 64'h48, ~amo_pkg::SIGN_BIT,
			amo_pkg::SIGN_BIT, 1'b0));
		send_request(make_req(amo_pkg::OP_AND, 1'b0, 64'h2, '1, '1, 1'b0));
		send_request(make_req(amo_pkg::OP_MAX, 1'b1, 64'h50, '1, '1, 1'b1));
		send_request(make_req(OP_UNUSED_LO, 1'b1, 64'h58, '1, '1, 1'b0));
		send_request(make_req(OP_UNUSED_HI, 1'b0, 64'h5C, '1, '1, 1'b1));
		drain_results();

		addr_pool[0] = '0;
		addr_pool[1] = ~64'h7;
		addr_pool[2] = {$urandom, $urandom} & ~64'h7;
		addr_pool[3] = {$urandom, $urandom} & ~64'h7;
		base = sent_count;
		while (sent_count - base < RANDOM_ITEMS) begin
			calm = (sent_count - base) >= RANDOM_ITEMS * 7 / 8;
			if ($urandom_range(0, 49) == 0)
				gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
			kind = $urandom_range(0, 99);
			if (kind < 45)
				lr_sc_sequence();
			else if (kind < 85)
				random_amo();
			else
				random_noise();
		end

		req_ch.valid <= 1'b0;
		do @(posedge clk); while (amo_sb.expected_rsps.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (amo_sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
